FILE: design/deq_pkg.sv
// Shared constants, operation and status codes, and controller command type
// for the double-ended queue. No dependencies.
package deq_pkg;

  localparam int unsigned DEPTH     = 1024;
  localparam int unsigned WORD_BITS = 64;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  // compare width: wide enough for the held count and for the 11-bit fields
  localparam int unsigned CMP_W = (CNT_W > 11) ? CNT_W : 11;

  localparam logic [10:0] LIMIT_RESET = 11'd1024;

  typedef enum logic [3:0] {
    OP_PUSH_BACK  = 4'd0,
    OP_PUSH_FRONT = 4'd1,
    OP_POP_BACK   = 4'd2,
    OP_POP_FRONT  = 4'd3,
    OP_GET_BACK   = 4'd4,
    OP_SET_BACK   = 4'd5,
    OP_GET_FRONT  = 4'd6,
    OP_SET_FRONT  = 4'd7,
    OP_GET_AT     = 4'd8,
    OP_SET_AT     = 4'd9,
    OP_CLEAR      = 4'd10
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic capture;  // latch the incoming item
    logic exec;     // perform the latched operation
  } ctl_cmd_t;

endpackage

FILE: design/deq_if.sv
// Valid/ready channel interfaces for operation items and result items.
// No dependencies; field widths are fixed here.
interface deq_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [9:0]  position;
  logic [63:0] write_value;

  modport source (output valid, output mode, output position, output write_value,
                  input ready);
  modport sink   (input valid, input mode, input position, input write_value,
                  output ready);
endinterface

interface deq_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_value;
  logic [1:0]  status;
  logic [10:0] entry_count;

  modport source (output valid, output read_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input read_value, input status, input entry_count,
                  output ready);
endinterface

FILE: design/deq_ctrl.sv
// Sequencing controller: accept one item, execute it, present the result.
// Depends on deq_pkg.
module deq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output deq_pkg::ctl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_o  <= 1'b1;
      out_valid_o <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q    <= S_EXEC;
            in_ready_o <= 1'b0;
          end
        end
        S_EXEC: begin
          state_q     <= S_OUT;
          out_valid_o <= 1'b1;
        end
        S_OUT: begin
          if (out_ready_i) begin
            state_q     <= S_IDLE;
            out_valid_o <= 1'b0;
            in_ready_o  <= 1'b1;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          out_valid_o <= 1'b0;
          in_ready_o  <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o.capture = in_valid_i && in_ready_o;
    cmd_o.exec    = (state_q == S_EXEC);
  end

endmodule

FILE: design/deq_datapath.sv
// Datapath: item latch, ring pointers, held count, limit register, entry
// memory with registered read, and result registers. Depends on deq_pkg.
module deq_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  deq_pkg::ctl_cmd_t cmd_i,
  input  logic              cfg_we_i,
  input  logic [10:0]       cfg_wdata_i,
  input  logic [3:0]        mode_i,
  input  logic [9:0]        position_i,
  input  logic [63:0]       write_value_i,
  output logic [63:0]       read_value_o,
  output logic [1:0]        status_o,
  output logic [10:0]       entry_count_o
);

  localparam int unsigned PW = deq_pkg::PTR_W;
  localparam int unsigned CW = deq_pkg::CNT_W;
  localparam int unsigned MW = deq_pkg::CMP_W;
  localparam int unsigned WB = deq_pkg::WORD_BITS;

  logic [WB-1:0] mem [deq_pkg::DEPTH];

  logic [3:0]    mode_q;
  logic [9:0]    pos_q;
  logic [WB-1:0] wv_q;
  logic [10:0]   limit_q;
  logic [PW-1:0] front_q, front_d;
  logic [PW-1:0] back_q, back_d;
  logic [CW-1:0] held_q, held_d;
  logic [WB-1:0] rd_q;
  logic          hit_q;
  deq_pkg::status_e st_q, st;

  logic [PW-1:0] addr;
  logic          we, re;
  logic          full, empty, range_bad;
  logic [PW-1:0] back_prev, back_next, front_prev, front_next, at_addr;
  logic [MW:0]   at_sum, at_wrap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= deq_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      pos_q  <= position_i;
      wv_q   <= write_value_i[WB-1:0];
    end
  end

  assign full = (MW'(held_q) >= MW'(limit_q)) || (held_q >= CW'(deq_pkg::DEPTH));
  assign empty     = (held_q == '0);
  assign range_bad = (MW'(pos_q) >= MW'(held_q));

  assign back_prev  = (back_q == '0) ? PW'(deq_pkg::DEPTH - 1) : back_q - PW'(1);
  assign back_next  = (back_q == PW'(deq_pkg::DEPTH - 1)) ? '0 : back_q + PW'(1);
  assign front_prev = (front_q == '0) ? PW'(deq_pkg::DEPTH - 1) : front_q - PW'(1);
  assign front_next = (front_q == PW'(deq_pkg::DEPTH - 1)) ? '0 : front_q + PW'(1);

  // position is below the count when used, so one conditional subtract wraps it
  assign at_sum  = (MW + 1)'(front_q) + (MW + 1)'(pos_q);
  assign at_wrap = (at_sum >= (MW + 1)'(deq_pkg::DEPTH)) ?
                   at_sum - (MW + 1)'(deq_pkg::DEPTH) : at_sum;
  assign at_addr = at_wrap[PW-1:0];

  always_comb begin
    st      = deq_pkg::ST_OK;
    addr    = front_q;
    we      = 1'b0;
    re      = 1'b0;
    front_d = front_q;
    back_d  = back_q;
    held_d  = held_q;
    unique case (deq_pkg::mode_e'(mode_q))
      deq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          st = deq_pkg::ST_FULL;
        end else begin
          we     = 1'b1;
          addr   = back_q;
          back_d = back_next;
          held_d = held_q + CW'(1);
        end
      end
      deq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          st = deq_pkg::ST_FULL;
        end else begin
          we      = 1'b1;
          addr    = front_prev;
          front_d = front_prev;
          held_d  = held_q + CW'(1);
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (empty) begin
          st = deq_pkg::ST_EMPTY;
        end else begin
          re     = 1'b1;
          addr   = back_prev;
          back_d = back_prev;
          held_d = held_q - CW'(1);
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          st = deq_pkg::ST_EMPTY;
        end else begin
          re      = 1'b1;
          addr    = front_q;
          front_d = front_next;
          held_d  = held_q - CW'(1);
        end
      end
      deq_pkg::OP_GET_BACK, deq_pkg::OP_SET_BACK: begin
        addr = back_prev;
        if (empty) begin
          st = deq_pkg::ST_EMPTY;
        end else if (mode_q == deq_pkg::OP_GET_BACK) begin
          re = 1'b1;
        end else begin
          we = 1'b1;
        end
      end
      deq_pkg::OP_GET_FRONT, deq_pkg::OP_SET_FRONT: begin
        if (empty) begin
          st = deq_pkg::ST_EMPTY;
        end else if (mode_q == deq_pkg::OP_GET_FRONT) begin
          re = 1'b1;
        end else begin
          we = 1'b1;
        end
      end
      deq_pkg::OP_GET_AT, deq_pkg::OP_SET_AT: begin
        addr = at_addr;
        if (range_bad) begin
          st = deq_pkg::ST_RANGE;
        end else if (mode_q == deq_pkg::OP_GET_AT) begin
          re = 1'b1;
        end else begin
          we = 1'b1;
        end
      end
      deq_pkg::OP_CLEAR: begin
        front_d = '0;
        back_d  = '0;
        held_d  = '0;
      end
      default: begin
        // unused codes: no effect, status ok
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      held_q  <= '0;
    end else if (cmd_i.exec) begin
      front_q <= front_d;
      back_q  <= back_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      st_q  <= st;
      hit_q <= re;
      if (we) begin
        mem[addr] <= wv_q;
      end
      if (re) begin
        rd_q <= mem[addr];
      end
    end
  end

  assign read_value_o  = hit_q ? 64'(rd_q) : 64'd0;
  assign status_o      = st_q;
  assign entry_count_o = 11'(held_q);

endmodule

FILE: design/double_ended_queue.sv
// Ring deque of data words with front/back push, pop, get, set and
// positional access in one memory. The result is registered: it is valid
// once the item has passed the execute state. No new item is taken until
// its result has been handed off; the controller runs latch, execute (memory
// access with registered read) and result hand-off for one item at a time.
// Reset clears pointers and count and sets the limit to 1024; memory is not cleared.
module double_ended_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  deq_in_if.sink      in_ch_i,
  deq_out_if.source   out_ch_o
);

  deq_pkg::ctl_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch_i.valid),
    .in_ready_o  (in_ch_i.ready),
    .out_valid_o (out_ch_o.valid),
    .out_ready_i (out_ch_o.ready),
    .cmd_o       (cmd)
  );

  deq_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mode_i        (in_ch_i.mode),
    .position_i    (in_ch_i.position),
    .write_value_i (in_ch_i.write_value),
    .read_value_o  (out_ch_o.read_value),
    .status_o      (out_ch_o.status),
    .entry_count_o (out_ch_o.entry_count)
  );

endmodule

FILE: design/deq_checker.sv
// Port-level checks for double_ended_queue, attached by bind.
// Depends on deq_pkg for status codes.
module deq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] read_value_i,
  input logic [1:0]  status_i,
  input logic [10:0] entry_count_i
);

  // a transfer in yields a result once the item has been executed
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> ##1 out_valid_i)
    else $error("result not presented two cycles after input transfer");

  // one item in flight: no input taken while a result waits
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while result pending");

  // failed operations read nothing
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (status_i != deq_pkg::ST_OK)) |-> (read_value_i == 64'd0))
    else $error("nonzero read value on failed operation");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (entry_count_i <= 11'd1024))
    else $error("entry count above capacity");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(read_value_i) && $stable(status_i) && $stable(entry_count_i)))
    else $error("stalled result changed");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_ch_i.valid),
  .in_ready_i    (in_ch_i.ready),
  .out_valid_i   (out_ch_o.valid),
  .out_ready_i   (out_ch_o.ready),
  .read_value_i  (out_ch_o.read_value),
  .status_i      (out_ch_o.status),
  .entry_count_i (out_ch_o.entry_count)
);

FILE: verif/tb.sv
// Self-checking testbench for double_ended_queue: drives operation items over the
// input channel, predicts each result in a local ring model and checks the result channel.
// Depends on deq_pkg, deq_in_if, deq_out_if and the double_ended_queue RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PW = deq_pkg::PTR_W;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CHUNK_ITEMS = 40;
  localparam logic [3:0] MODE_SPARE_FIRST = 4'd11;
  localparam logic [3:0] MODE_SPARE_LAST  = 4'hF;

  typedef struct packed {
    logic [63:0]      rd;
    deq_pkg::status_e st;
    logic [10:0]      cnt;
  } deq_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [10:0] cfg_wdata;

  deq_in_if  in_ch ();
  deq_out_if out_ch ();

  double_ended_queue dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_ch_i    (in_ch),
    .out_ch_o   (out_ch)
  );

  // local copy of the ring
  logic [63:0]   ring_mem [deq_pkg::DEPTH];
  logic [PW-1:0] head = '0;
  logic [PW-1:0] tail = '0;
  logic [10:0]   fill = '0;
  logic [10:0]   cap_limit = deq_pkg::LIMIT_RESET;

  deq_res_t    res_pending [$];
  int unsigned fail_cnt = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  bit          hold_req = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Ring arithmetic wraps at the pointer width since DEPTH is a power of two.
  function automatic deq_res_t apply_deq_op(logic [3:0] m, logic [9:0] pos,
                                            logic [63:0] wv);
    deq_res_t      r;
    logic [10:0]   lim;
    logic [PW-1:0] a;
    r.rd = '0;
    r.st = deq_pkg::ST_OK;
    lim = (cap_limit < deq_pkg::DEPTH) ? cap_limit : 11'(deq_pkg::DEPTH);
    case (m)
      deq_pkg::OP_PUSH_BACK, deq_pkg::OP_PUSH_FRONT: begin
        if (fill >= lim) begin
          r.st = deq_pkg::ST_FULL;
        end else begin
          if (m == deq_pkg::OP_PUSH_BACK) begin
            ring_mem[tail] = wv;
            tail = tail + PW'(1);
          end else begin
            head = head - PW'(1);
            ring_mem[head] = wv;
          end
          fill = fill + 11'd1;
        end
      end
      deq_pkg::OP_POP_BACK, deq_pkg::OP_POP_FRONT, deq_pkg::OP_GET_BACK,
      deq_pkg::OP_SET_BACK, deq_pkg::OP_GET_FRONT, deq_pkg::OP_SET_FRONT: begin
        a = tail - PW'(1);
        if (fill == '0) begin
          r.st = deq_pkg::ST_EMPTY;
        end else begin
          case (m)
            deq_pkg::OP_POP_BACK: begin
              tail = a;
              r.rd = ring_mem[a];
              fill = fill - 11'd1;
            end
            deq_pkg::OP_POP_FRONT: begin
              r.rd = ring_mem[head];
              head = head + PW'(1);
              fill = fill - 11'd1;
            end
            deq_pkg::OP_GET_BACK:  r.rd = ring_mem[a];
            deq_pkg::OP_SET_BACK:  ring_mem[a] = wv;
            deq_pkg::OP_GET_FRONT: r.rd = ring_mem[head];
            default:               ring_mem[head] = wv;
          endcase
        end
      end
      deq_pkg::OP_GET_AT, deq_pkg::OP_SET_AT: begin
        if (11'(pos) >= fill) begin
          r.st = deq_pkg::ST_RANGE;
        end else begin
          a = head + pos;
          if (m == deq_pkg::OP_GET_AT) r.rd = ring_mem[a];
          else ring_mem[a] = wv;
        end
      end
      deq_pkg::OP_CLEAR: begin
        head = '0;
        tail = '0;
        fill = '0;
      end
      default: ;
    endcase
    r.cnt = fill;
    return r;
  endfunction

  // Offer one item after a random gap; returns at the edge of its transfer.
  task automatic send_op(logic [3:0] m, logic [9:0] pos, logic [63:0] wv);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= m;
    in_ch.position    <= pos;
    in_ch.write_value <= wv;
    do @(posedge clk_i); while (!in_ch.ready);
    res_pending.push_back(apply_deq_op(m, pos, wv));
  endtask

  task automatic send_random_op();
    int unsigned pick;
    logic [3:0]  m;
    logic [9:0]  pos;
    pick = $urandom_range(99);
    if (pick < 18)      m = deq_pkg::OP_PUSH_BACK;
    else if (pick < 36) m = deq_pkg::OP_PUSH_FRONT;
    else if (pick < 46) m = deq_pkg::OP_POP_BACK;
    else if (pick < 56) m = deq_pkg::OP_POP_FRONT;
    else if (pick < 61) m = deq_pkg::OP_GET_BACK;
    else if (pick < 66) m = deq_pkg::OP_SET_BACK;
    else if (pick < 71) m = deq_pkg::OP_GET_FRONT;
    else if (pick < 76) m = deq_pkg::OP_SET_FRONT;
    else if (pick < 85) m = deq_pkg::OP_GET_AT;
    else if (pick < 94) m = deq_pkg::OP_SET_AT;
    else if (pick < 96) m = deq_pkg::OP_CLEAR;
    else m = 4'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
    if (fill != '0 && $urandom_range(9) < 8) pos = 10'($urandom_range(fill - 1));
    else pos = 10'($urandom);
    send_op(m, pos, {$urandom, $urandom});
  endtask

  // Stop offering and let every outstanding result come back.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (res_pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [10:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cap_limit = v;
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_op(deq_pkg::OP_POP_BACK, '0, '0);
    send_op(deq_pkg::OP_POP_FRONT, '0, '0);
    send_op(deq_pkg::OP_GET_BACK, '0, '0);
    send_op(deq_pkg::OP_SET_BACK, '0, '1);
    send_op(deq_pkg::OP_GET_FRONT, '0, '0);
    send_op(deq_pkg::OP_SET_FRONT, '0, '1);
    send_op(deq_pkg::OP_GET_AT, '0, '0);      // out of range while empty
    send_op(deq_pkg::OP_SET_AT, '1, '1);
    send_op(deq_pkg::OP_PUSH_BACK, '0, '1);
    send_op(deq_pkg::OP_PUSH_FRONT, '1, '0);  // front wraps to the top slot
    send_op(deq_pkg::OP_PUSH_BACK, '0, {$urandom, $urandom});
    send_op(deq_pkg::OP_GET_AT, 10'd0, '0);
    send_op(deq_pkg::OP_GET_AT, 10'd2, '0);
    send_op(deq_pkg::OP_GET_AT, 10'd3, '0);
    send_op(deq_pkg::OP_SET_AT, 10'd1, 64'hA5A5_5A5A_0F0F_F0F0);
    send_op(deq_pkg::OP_GET_BACK, '0, '0);
    send_op(deq_pkg::OP_GET_FRONT, '0, '0);
    send_op(deq_pkg::OP_SET_BACK, '0, 64'h0123_4567_89AB_CDEF);
    send_op(deq_pkg::OP_SET_FRONT, '0, 64'hFEDC_BA98_7654_3210);
    send_op(deq_pkg::OP_GET_AT, 10'd1, '0);
    send_op(deq_pkg::OP_POP_BACK, '0, '0);
    send_op(deq_pkg::OP_POP_FRONT, '0, '0);
    send_op(MODE_SPARE_FIRST, '1, '1);
    send_op(MODE_SPARE_LAST, '0, '0);
    send_op(deq_pkg::OP_CLEAR, '0, '0);
    wait_idle();
  endtask

  task automatic test_limits();
    write_limit(11'd3);
    send_op(deq_pkg::OP_PUSH_BACK, '0, {$urandom, $urandom});
    send_op(deq_pkg::OP_PUSH_FRONT, '0, {$urandom, $urandom});
    send_op(deq_pkg::OP_PUSH_BACK, '0, {$urandom, $urandom});
    send_op(deq_pkg::OP_PUSH_FRONT, '0, {$urandom, $urandom});  // full
    // limit below the count: entries stay, pushes report full
    write_limit(11'd1);
    send_op(deq_pkg::OP_PUSH_BACK, '0, {$urandom, $urandom});
    send_op(deq_pkg::OP_GET_AT, 10'd2, '0);
    send_op(deq_pkg::OP_SET_AT, 10'd0, {$urandom, $urandom});
    send_op(deq_pkg::OP_POP_FRONT, '0, '0);
    write_limit(11'd0);
    send_op(deq_pkg::OP_PUSH_BACK, '0, {$urandom, $urandom});
    send_op(deq_pkg::OP_PUSH_FRONT, '0, {$urandom, $urandom});
    send_op(deq_pkg::OP_POP_BACK, '0, '0);
    send_op(deq_pkg::OP_POP_FRONT, '0, '0);
    send_op(deq_pkg::OP_POP_BACK, '0, '0);    // empty
    write_limit(11'h7FF);
    send_op(deq_pkg::OP_PUSH_BACK, '0, {$urandom, $urandom});
    send_op(deq_pkg::OP_CLEAR, '0, '0);
    wait_idle();
  endtask

  task automatic test_backpressure();
    int unsigned saved_pct;
    wait_idle();
    saved_pct = src_idle_pct;
    src_idle_pct = 0;
    hold_req = 1'b1;
    repeat (16) send_random_op();
    src_idle_pct = saved_pct;
    wait_idle();
  endtask

  // the front end moves across slot zero, positional access spans the wrap
  task automatic test_ring_wrap();
    write_limit(11'h7FF);
    send_op(deq_pkg::OP_CLEAR, '0, '0);
    repeat (6) send_op(deq_pkg::OP_PUSH_FRONT, '0, {$urandom, $urandom});
    repeat (6) send_op(deq_pkg::OP_PUSH_BACK, '0, {$urandom, $urandom});
    for (int unsigned i = 0; i < 13; i++) begin
      send_op(deq_pkg::OP_GET_AT, 10'(i), '0);
    end
    send_op(deq_pkg::OP_SET_AT, 10'd5, {$urandom, $urandom});
    send_op(deq_pkg::OP_SET_AT, 10'd6, {$urandom, $urandom});
    send_op(deq_pkg::OP_GET_AT, 10'd5, '0);
    repeat (7) begin
      send_op(deq_pkg::OP_POP_BACK, '0, '0);
      send_op(deq_pkg::OP_POP_FRONT, '0, '0);
    end
    wait_idle();
  endtask

  task automatic test_random(int unsigned n);
    int unsigned pick;
    logic [10:0] lim;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % CHUNK_ITEMS == 0) begin
        pick = $urandom_range(9);
        if (pick < 6)       lim = 11'($urandom_range(16, 1));
        else if (pick == 6) lim = 11'd0;
        else if (pick == 7) lim = 11'(deq_pkg::DEPTH);
        else if (pick == 8) lim = 11'h7FF;
        else lim = 11'($urandom);
        write_limit(lim);
      end
      send_random_op();
    end
    wait_idle();
  endtask

  // result sink: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    deq_res_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (res_pending.size() == 0) begin
        $display("%0t: result transfer with nothing pending: read_value %h status %0d count %0d",
                 $time, out_ch.read_value, out_ch.status, out_ch.entry_count);
        fail_cnt++;
      end else begin
        want = res_pending.pop_front();
        if (out_ch.read_value !== want.rd) begin
          $display("%0t: read_value expected %h, actual %h", $time, want.rd, out_ch.read_value);
          fail_cnt++;
        end
        if (out_ch.status !== want.st) begin
          $display("%0t: status expected %0d, actual %0d", $time, want.st, out_ch.status);
          fail_cnt++;
        end
        if (out_ch.entry_count !== want.cnt) begin
          $display("%0t: entry_count expected %0d, actual %0d",
                   $time, want.cnt, out_ch.entry_count);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = '0;
    in_ch.position    = '0;
    in_ch.write_value = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 31;
    snk_idle_pct = 81;
    test_directed();
    test_limits();
    test_backpressure();
    test_random(250);

    src_idle_pct = 81;
    snk_idle_pct = 31;
    test_random(250);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_ring_wrap();
    test_random(240);

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0 && res_pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
